// File: design/wmre_pkg.sv
// ============================================================================
// wmre_pkg
// Shared types and constants of the window match run encoder.
// ============================================================================
package wmre_pkg;

  // Size of the byte history and the longest run beyond the first pair.
  localparam int unsigned HISTORY_DEPTH = 8;
  localparam int unsigned MAX_RUN_EXTRA = 7;

  // Field widths fixed by the code format.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned OFFSET_W    = 3;
  localparam int unsigned RUN_EXTRA_W = 3;
  localparam int unsigned CODE_W      = 9;
  localparam int unsigned LEN_W       = 4;

  // Code lengths in bits.
  localparam logic [LEN_W-1:0] LEN_EMPTY   = 4'd0;
  localparam logic [LEN_W-1:0] LEN_MATCH   = 4'd5;
  localparam logic [LEN_W-1:0] LEN_RUN     = 4'd8;
  localparam logic [LEN_W-1:0] LEN_LITERAL = 4'd9;

  // Input transaction.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_item_t;

  // Output transaction.
  typedef struct packed {
    logic [CODE_W-1:0] code_value;
    logic [LEN_W-1:0]  code_length;
    logic              last;
  } out_item_t;

  // Which code the datapath loads into the output register.
  typedef enum logic [2:0] {
    CODE_EMPTY,
    CODE_MATCH,
    CODE_RUN,
    CODE_RUN_INC,
    CODE_LITERAL
  } code_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      clear;
    logic      emit;
    logic      last;
    code_sel_e code_sel;
    logic      src_in;
    logic      push_held;
    logic      push_held2;
    logic      push_src;
    logic      hold;
    logic      run_inc;
    logic      run_clr;
    logic      capture_pend;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic in_eq_held;
    logic found;
    logic run_full;
  } dp_status_t;

endpackage

// File: design/wmre_datapath.sv
// ============================================================================
// wmre_datapath
// History shift line, match search, held match state and output register.
// ============================================================================
module wmre_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wmre_pkg::in_item_t  in_item_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output wmre_pkg::out_item_t out_item_o,
  input  wmre_pkg::dp_cmd_t   cmd_i,
  output wmre_pkg::dp_status_t status_o
);

  // History as a shift line: entry 0 is the newest byte, so the index is the offset.
  logic [wmre_pkg::BYTE_W-1:0]      hist_q [wmre_pkg::HISTORY_DEPTH];
  logic [wmre_pkg::BYTE_W-1:0]      held_byte_q;
  logic [wmre_pkg::OFFSET_W-1:0]    held_offset_q;
  logic [wmre_pkg::RUN_EXTRA_W-1:0] run_extra_q;
  logic [wmre_pkg::BYTE_W-1:0]      pend_byte_q;
  logic                             out_valid_q;
  wmre_pkg::out_item_t              out_q;
  wmre_pkg::out_item_t              out_d;

  logic [wmre_pkg::BYTE_W-1:0]      src_byte;
  logic                             found;
  logic [wmre_pkg::OFFSET_W-1:0]    found_off;
  logic [wmre_pkg::RUN_EXTRA_W:0]   run_sum;

  // The byte to encode afresh is the incoming one or the one parked for the second step.
  assign src_byte = cmd_i.src_in ? in_item_i.data_byte : pend_byte_q;

  // Parallel compare against every history entry; the smallest offset wins.
  always_comb begin
    found     = 1'b0;
    found_off = '0;
    for (int o = wmre_pkg::HISTORY_DEPTH - 1; o >= 0; o--) begin
      if (hist_q[o] == src_byte) begin
        found     = 1'b1;
        found_off = wmre_pkg::OFFSET_W'(o);
      end
    end
  end

  assign run_sum = {1'b0, run_extra_q} + {{wmre_pkg::RUN_EXTRA_W{1'b0}}, 1'b1};

  assign status_o.out_free   = !out_valid_q || !out_stall_i;
  assign status_o.in_eq_held = (in_item_i.data_byte == held_byte_q);
  assign status_o.found      = found;
  assign status_o.run_full   =
    (run_sum >= (wmre_pkg::RUN_EXTRA_W + 1)'(wmre_pkg::MAX_RUN_EXTRA));

  // History update: clear at end of stream, otherwise shift in one or two bytes on a push.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < wmre_pkg::HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cmd_i.clear) begin
      for (int i = 0; i < wmre_pkg::HISTORY_DEPTH; i++) begin
        hist_q[i] <= '0;
      end
    end else if (cmd_i.push_held2) begin
      hist_q[0] <= held_byte_q;
      hist_q[1] <= held_byte_q;
      for (int i = 2; i < wmre_pkg::HISTORY_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-2];
      end
    end else if (cmd_i.push_held || cmd_i.push_src) begin
      hist_q[0] <= cmd_i.push_held ? held_byte_q : src_byte;
      for (int i = 1; i < wmre_pkg::HISTORY_DEPTH; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

  // Held match byte, its offset and the run length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q   <= '0;
      held_offset_q <= '0;
      run_extra_q   <= '0;
    end else if (cmd_i.clear) begin
      held_byte_q   <= '0;
      held_offset_q <= '0;
      run_extra_q   <= '0;
    end else if (cmd_i.hold) begin
      held_byte_q   <= src_byte;
      held_offset_q <= found_off;
      run_extra_q   <= '0;
    end else if (cmd_i.run_clr) begin
      run_extra_q   <= '0;
    end else if (cmd_i.run_inc) begin
      run_extra_q   <= run_sum[wmre_pkg::RUN_EXTRA_W-1:0];
    end
  end

  // Byte parked for a second step of encoding.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture_pend) begin
      pend_byte_q <= in_item_i.data_byte;
    end
  end

  // Code formation for the selected kind of code.
  always_comb begin
    out_d.last = cmd_i.last;
    case (cmd_i.code_sel)
      wmre_pkg::CODE_MATCH: begin
        out_d.code_value  = {{(wmre_pkg::CODE_W - wmre_pkg::OFFSET_W){1'b0}}, held_offset_q};
        out_d.code_length = wmre_pkg::LEN_MATCH;
      end
      wmre_pkg::CODE_RUN: begin
        out_d.code_value  = {2'b00, 1'b1, held_offset_q, run_extra_q};
        out_d.code_length = wmre_pkg::LEN_RUN;
      end
      wmre_pkg::CODE_RUN_INC: begin
        out_d.code_value  = {2'b00, 1'b1, held_offset_q,
                             run_sum[wmre_pkg::RUN_EXTRA_W-1:0]};
        out_d.code_length = wmre_pkg::LEN_RUN;
      end
      wmre_pkg::CODE_LITERAL: begin
        out_d.code_value  = {1'b1, src_byte};
        out_d.code_length = wmre_pkg::LEN_LITERAL;
      end
      default: begin
        out_d.code_value  = '0;
        out_d.code_length = wmre_pkg::LEN_EMPTY;
      end
    endcase
  end

  // Output valid: set on a new code, cleared when the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// File: design/wmre_ctrl.sv
// ============================================================================
// wmre_ctrl
// Controller: encoder mode and the two-step sequence for a code that ends
// a pending match or run.
// ============================================================================
module wmre_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_eos_i,
  output logic                 in_stall_o,
  input  wmre_pkg::dp_status_t status_i,
  output wmre_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic {
    ST_ACCEPT,
    ST_FRESH
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_HELD,
    MODE_RUN
  } mode_e;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   accept;
  logic   do_fresh;

  // Input is taken only in the accept state and when the output register is free.
  assign in_stall_o = !((state_q == ST_ACCEPT) && status_i.out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Next state and datapath commands.
  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    do_fresh = 1'b0;
    cmd_o          = '0;
    cmd_o.code_sel = wmre_pkg::CODE_EMPTY;
    cmd_o.src_in   = (state_q == ST_ACCEPT);

    case (state_q)
      ST_ACCEPT: begin
        if (accept) begin
          if (in_eos_i) begin
            // End of stream flushes whatever is pending and restarts.
            cmd_o.emit  = 1'b1;
            cmd_o.last  = 1'b1;
            cmd_o.clear = 1'b1;
            mode_d      = MODE_IDLE;
            case (mode_q)
              MODE_HELD: cmd_o.code_sel = wmre_pkg::CODE_MATCH;
              MODE_RUN:  cmd_o.code_sel = wmre_pkg::CODE_RUN;
              default:   cmd_o.code_sel = wmre_pkg::CODE_EMPTY;
            endcase
          end else begin
            case (mode_q)
              MODE_HELD: begin
                if (status_i.in_eq_held) begin
                  cmd_o.push_held2 = 1'b1;
                  cmd_o.run_clr    = 1'b1;
                  mode_d           = MODE_RUN;
                end else begin
                  cmd_o.emit         = 1'b1;
                  cmd_o.code_sel     = wmre_pkg::CODE_MATCH;
                  cmd_o.push_held    = 1'b1;
                  cmd_o.capture_pend = 1'b1;
                  state_d            = ST_FRESH;
                end
              end
              MODE_RUN: begin
                if (status_i.in_eq_held) begin
                  cmd_o.push_held = 1'b1;
                  if (status_i.run_full) begin
                    cmd_o.emit     = 1'b1;
                    cmd_o.code_sel = wmre_pkg::CODE_RUN_INC;
                    cmd_o.run_clr  = 1'b1;
                    mode_d         = MODE_IDLE;
                  end else begin
                    cmd_o.run_inc = 1'b1;
                  end
                end else begin
                  cmd_o.emit         = 1'b1;
                  cmd_o.code_sel     = wmre_pkg::CODE_RUN;
                  cmd_o.run_clr      = 1'b1;
                  cmd_o.capture_pend = 1'b1;
                  state_d            = ST_FRESH;
                end
              end
              default: begin
                do_fresh = 1'b1;
              end
            endcase
          end
        end
      end
      ST_FRESH: begin
        if (status_i.out_free) begin
          do_fresh = 1'b1;
          state_d  = ST_ACCEPT;
        end
      end
      default: begin
        state_d = ST_ACCEPT;
      end
    endcase

    // Fresh encoding: hold a byte found in the history, otherwise send a literal.
    if (do_fresh) begin
      if (status_i.found) begin
        cmd_o.hold = 1'b1;
        mode_d     = MODE_HELD;
      end else begin
        cmd_o.emit     = 1'b1;
        cmd_o.code_sel = wmre_pkg::CODE_LITERAL;
        cmd_o.push_src = 1'b1;
        mode_d         = MODE_IDLE;
      end
    end
  end

  // State and mode registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACCEPT;
      mode_q  <= MODE_IDLE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  // No input is taken while the second step of an item is still due.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FRESH) |-> in_stall_o)
    else $error("input accepted during second encoding step");

  // A code is only loaded when the output register can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> status_i.out_free)
    else $error("pending output code overwritten");

  // At most one kind of history push per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.push_held, cmd_o.push_held2, cmd_o.push_src}))
    else $error("conflicting history pushes");

  // End of stream always returns the encoder to its idle start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_eos_i) |=> ((mode_q == MODE_IDLE) && (state_q == ST_ACCEPT)))
    else $error("encoder not idle after end of stream");

endmodule

// File: design/window_match_run_encoder_core.sv
// ============================================================================
// window_match_run_encoder_core
// Byte stream encoder against an eight-byte history with run-length codes.
// ============================================================================
// A byte is taken whenever the output register is free; a byte that ends a
// pending match or run first flushes that code, and its own encoding is searched
// in a second step against the history as that first step left
// it, after the flushed code has gone to the output register. The output
// register holds one code, so a stalled output holds back the input side.
// Codes are right aligned with the first sent bit most significant: a literal
// is 9 bits, a single match 5 bits, a run 8 bits, and an end of stream with
// nothing pending gives one empty code; the code caused by end of stream
// carries last, and the history then starts again from zeros.
module window_match_run_encoder_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  wmre_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output wmre_pkg::out_item_t out_item_o
);

  wmre_pkg::dp_cmd_t    cmd;
  wmre_pkg::dp_status_t status;

  // Sequencing of each transaction.
  wmre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_eos_i   (in_item_i.end_of_stream),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // History, search and output register.
  wmre_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

// File: tb/wmre_code_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// wmre_code_checker
// Predicts and checks the codes of the window match run encoder.
// ============================================================================
// The checker watches both channels of the encoder. It keeps its own copy of
// the byte window and of the pending match or run, works out the codes that
// each input transaction causes, and compares every output transaction field
// by field with the oldest code that is still owed. The failure count and the
// number of owed codes go to the testbench top.
module wmre_code_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  wmre_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  wmre_pkg::out_item_t out_item_i,
  output int                  fail_count_o,
  output int                  open_count_o
);

  localparam int DEPTH = int'(wmre_pkg::HISTORY_DEPTH);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_MATCH,
    PH_RUN
  } phase_e;

  // Model state.
  logic [wmre_pkg::BYTE_W-1:0]   window [DEPTH];
  int                            wr_idx;
  phase_e                        phase;
  logic [wmre_pkg::BYTE_W-1:0]   held_val;
  logic [wmre_pkg::OFFSET_W-1:0] held_pos;
  int                            run_len;

  // Codes owed by the encoder, oldest first.
  wmre_pkg::out_item_t           owed_codes [$];
  wmre_pkg::out_item_t           want;
  logic                          offer_seen;

  // Return every piece of model state to its value after reset.
  task automatic clear_state();
    for (int i = 0; i < DEPTH; i++) begin
      window[i] = '0;
    end
    wr_idx   = 0;
    phase    = PH_IDLE;
    held_val = '0;
    held_pos = '0;
    run_len  = 0;
  endtask

  task automatic owe_code(logic [wmre_pkg::CODE_W-1:0] value,
                          logic [wmre_pkg::LEN_W-1:0] len, logic lst);
    wmre_pkg::out_item_t c;
    c.code_value  = value;
    c.code_length = len;
    c.last        = lst;
    owed_codes.push_back(c);
  endtask

  task automatic shift_in(logic [wmre_pkg::BYTE_W-1:0] b);
    window[wr_idx] = b;
    wr_idx = (wr_idx + 1) % DEPTH;
  endtask

  // Smallest back offset at which the byte sits, newest entry first; -1 if absent.
  function automatic int window_offset(logic [wmre_pkg::BYTE_W-1:0] b);
    int idx;
    for (int o = 0; o < DEPTH; o++) begin
      idx = (wr_idx + 2 * DEPTH - 1 - o) % DEPTH;
      if (window[idx] == b) begin
        return o;
      end
    end
    return -1;
  endfunction

  function automatic logic [wmre_pkg::CODE_W-1:0] run_word();
    return 9'h040 | (9'(held_pos) << 3) | 9'(run_len[wmre_pkg::RUN_EXTRA_W-1:0]);
  endfunction

  // A byte with nothing pending: either a literal, or it is held for a match.
  task automatic code_byte(logic [wmre_pkg::BYTE_W-1:0] b);
    int off;
    off = window_offset(b);
    if (off < 0) begin
      owe_code(9'h100 | 9'(b), wmre_pkg::LEN_LITERAL, 1'b0);
      shift_in(b);
      phase = PH_IDLE;
    end else begin
      held_val = b;
      held_pos = wmre_pkg::OFFSET_W'(off);
      run_len  = 0;
      phase    = PH_MATCH;
    end
  endtask

  // Work out the codes that one input transaction causes.
  task automatic predict_codes(wmre_pkg::in_item_t it);
    if (it.end_of_stream) begin
      case (phase)
        PH_MATCH: owe_code(9'(held_pos), wmre_pkg::LEN_MATCH, 1'b1);
        PH_RUN:   owe_code(run_word(), wmre_pkg::LEN_RUN, 1'b1);
        default:  owe_code('0, wmre_pkg::LEN_EMPTY, 1'b1);
      endcase
      clear_state();
    end else begin
      case (phase)
        PH_MATCH: begin
          if (it.data_byte == held_val) begin
            shift_in(held_val);
            shift_in(held_val);
            run_len = 0;
            phase   = PH_RUN;
          end else begin
            owe_code(9'(held_pos), wmre_pkg::LEN_MATCH, 1'b0);
            shift_in(held_val);
            code_byte(it.data_byte);
          end
        end
        PH_RUN: begin
          if (it.data_byte == held_val) begin
            shift_in(it.data_byte);
            run_len = (run_len + 1) & 7;
            // A full run is sent at once and the next byte starts afresh.
            if (run_len >= int'(wmre_pkg::MAX_RUN_EXTRA)) begin
              owe_code(run_word(), wmre_pkg::LEN_RUN, 1'b0);
              phase   = PH_IDLE;
              run_len = 0;
            end
          end else begin
            owe_code(run_word(), wmre_pkg::LEN_RUN, 1'b0);
            run_len = 0;
            code_byte(it.data_byte);
          end
        end
        default: code_byte(it.data_byte);
      endcase
    end
  endtask

  // The sender never withdraws an offered transaction, so it is predicted as
  // soon as it is offered. Prediction comes before the output check of the
  // same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      owed_codes.delete();
      offer_seen   = 1'b0;
      fail_count_o = 0;
      open_count_o = 0;
    end else begin
      if (in_valid_i && !offer_seen) begin
        predict_codes(in_item_i);
      end
      offer_seen = in_valid_i && in_stall_i;

      if (out_valid_i && !out_stall_i) begin
        if (owed_codes.size() == 0) begin
          $error("unexpected code: value %0h, length %0d, last %0b",
                 out_item_i.code_value, out_item_i.code_length, out_item_i.last);
          fail_count_o++;
        end else begin
          want = owed_codes.pop_front();
          if (out_item_i.code_value != want.code_value) begin
            $error("code_value: expected %0h, got %0h",
                   want.code_value, out_item_i.code_value);
            fail_count_o++;
          end
          if (out_item_i.code_length != want.code_length) begin
            $error("code_length: expected %0d, got %0d",
                   want.code_length, out_item_i.code_length);
            fail_count_o++;
          end
          if (out_item_i.last != want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_item_i.last);
            fail_count_o++;
          end
        end
      end
      open_count_o = owed_codes.size();
    end
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stimulus and verdict for the window match run encoder.
// ============================================================================
// A short directed stream covers literals, single matches, runs that break,
// a full run, and end of stream with and without a pending code. A long
// random stream follows, built mostly from a small set of bytes and from
// runs of equal bytes so that matches at every offset and runs of every
// length occur, with random bytes and ends of stream mixed in. Both sides
// idle in short random bursts, and once the receiver holds off long enough
// for the encoder to stall its input. The checker beside the encoder does
// all prediction and comparison.
module testbench;

  localparam int RANDOM_ITEMS = 1600;
  localparam int CALM_ITEMS   = 200;
  localparam int SQUEEZE_AT   = 500;
  localparam int SQUEEZE_LEN  = 80;
  localparam int DRAIN_CYCLES = 16;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  wmre_pkg::in_item_t  in_item_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  wmre_pkg::out_item_t out_item_o;

  int        fail_count;
  int        open_count;
  int        items_sent  = 0;
  int        idle_pct    = 0;
  int        stall_pct   = 0;

  always #2 clk_i = ~clk_i;

  window_match_run_encoder_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  wmre_code_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  // Offer one input transaction, after an optional idle burst, and wait until
  // it is taken. Valid stays high between back-to-back transactions.
  task automatic offer(input logic [wmre_pkg::BYTE_W-1:0] b, input logic eos);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= '{data_byte: b, end_of_stream: eos};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Receiver: short random stall bursts, and one long hold-off.
  initial begin : receiver
    int hold_left;
    bit squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (!squeezed && items_sent >= SQUEEZE_AT) begin
        hold_left = SQUEEZE_LEN;
        squeezed  = 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        hold_left = $urandom_range(1, 4);
      end
      out_stall_i <= (hold_left > 0);
    end
  end

  // Stimulus and verdict.
  initial begin : stimulus
    logic [wmre_pkg::BYTE_W-1:0] symbols [4];
    logic [wmre_pkg::BYTE_W-1:0] run_byte;
    int                          run_left;
    int                          r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed stream.
    idle_pct  = 25;
    stall_pct = 25;
    offer(8'h5A, 1'b1);            // end of stream with nothing pending
    offer(8'h00, 1'b0);            // found in the zero window
    offer(8'hFF, 1'b0);            // breaks the match, then a literal
    offer(8'hFF, 1'b0);            // held
    repeat (8) offer(8'hFF, 1'b0); // run that fills up
    offer(8'h80, 1'b0);            // literal after a full run
    offer(8'h80, 1'b0);
    offer(8'h00, 1'b1);            // end of stream with a match pending
    offer(8'h55, 1'b0);
    offer(8'h55, 1'b0);
    offer(8'h55, 1'b0);
    offer(8'hFF, 1'b1);            // end of stream with a run pending
    offer(8'h01, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'h01, 1'b0);
    offer(8'h02, 1'b0);            // broken run, then a literal
    offer(8'hA5, 1'b1);

    // Random stream.
    for (int k = 0; k < 4; k++) begin
      symbols[k] = 8'($urandom_range(0, 255));
    end
    run_byte = '0;
    run_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       idle_pct = 0;
          1:       idle_pct = 20;
          default: idle_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 20;
          default: stall_pct = 50;
        endcase
      end
      if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
        idle_pct  = 0;
        stall_pct = 0;
      end

      if (run_left > 0) begin
        run_left--;
        offer(run_byte, 1'b0);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // End of stream; the next stream draws a new symbol set.
          offer(8'($urandom_range(0, 255)), 1'b1);
          for (int k = 0; k < 4; k++) begin
            symbols[k] = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
          end
        end else if (r < 22) begin
          offer(8'($urandom_range(0, 255)), 1'b0);
        end else if (r < 60) begin
          offer(symbols[$urandom_range(0, 3)], 1'b0);
        end else begin
          run_byte = symbols[$urandom_range(0, 3)];
          run_left = $urandom_range(1, 11);
          offer(run_byte, 1'b0);
        end
      end
    end
    offer(8'($urandom_range(0, 255)), 1'b1);
    in_valid_i <= 1'b0;

    // Wait for every owed code, then for stray codes.
    @(negedge clk_i);
    while (open_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Limit on the whole run.
  initial begin : watchdog
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: sim.f
design/wmre_pkg.sv
design/wmre_datapath.sv
design/wmre_ctrl.sv
design/window_match_run_encoder_core.sv
tb/wmre_code_checker.sv
tb/testbench.sv
